[hdl/mp2d_pkg.sv]
package mp2d_pkg;

  // Sizing of the block.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_WIN     = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_HEIGHT  = 4096;

  // Widths of the configuration registers.
  localparam int IW_BITS   = 9;
  localparam int IH_BITS   = 13;
  localparam int WIN_BITS  = 3;
  localparam int STEP_BITS = 3;

  // Position counters and ring addressing.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int RR_W  = $clog2(MAX_WIN);
  localparam int WN_W  = $clog2(MAX_WIN + 1);
  localparam int CA_W  = COL_W + 2;
  localparam int RA_W  = ROW_W + 2;

  // Remainder unit: digits of DIG_BITS bits, one digit per cycle.
  localparam int DIG_BITS  = 4;
  localparam int DIV_RAW   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int DIV_W     = ((DIV_RAW + DIG_BITS - 1) / DIG_BITS) * DIG_BITS;
  localparam int DIV_STEPS = DIV_W / DIG_BITS;
  localparam int DSC_W     = $clog2(DIV_STEPS + 1);

  // Stream and register port sizing.
  localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int NUM_REGS  = 5;
  localparam int ADDR_W    = $clog2(4 * NUM_REGS);
  localparam int REG_IDX_W = ADDR_W - 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_WIN_ROWS     = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_WIN_COLS     = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE    = REG_IDX_W'(4);

  // Register reset values.
  localparam logic [IW_BITS-1:0]   RST_IMAGE_WIDTH  = IW_BITS'(256);
  localparam logic [IH_BITS-1:0]   RST_IMAGE_HEIGHT = IH_BITS'(256);
  localparam logic [WIN_BITS-1:0]  RST_WIN_ROWS     = WIN_BITS'(2);
  localparam logic [WIN_BITS-1:0]  RST_WIN_COLS     = WIN_BITS'(2);
  localparam logic [STEP_BITS-1:0] RST_STEP_SIZE    = STEP_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Raw register contents as written.
  typedef struct packed {
    logic [IW_BITS-1:0]   image_width;
    logic [IH_BITS-1:0]   image_height;
    logic [WIN_BITS-1:0]  win_rows;
    logic [WIN_BITS-1:0]  win_cols;
    logic [STEP_BITS-1:0] step_size;
  } cfg_t;

  // Register values after clamping into their working ranges.
  typedef struct packed {
    logic [CA_W-1:0]      w;
    logic [RA_W-1:0]      h;
    logic [WN_W-1:0]      wr;
    logic [WN_W-1:0]      wc;
    logic [STEP_BITS-1:0] s;
  } eff_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic pos_calc;
    logic prep;
    logic walk;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic hit;
    logic walk_done;
    logic out_busy;
  } stat_t;

  // Zero acts as one; values above the maximum act as the maximum.
  function automatic eff_t make_eff(cfg_t c);
    eff_t e;
    if (c.image_width == '0) begin
      e.w = CA_W'(1);
    end else if (32'(c.image_width) > 32'(MAX_WIDTH)) begin
      e.w = CA_W'(MAX_WIDTH);
    end else begin
      e.w = CA_W'(c.image_width);
    end
    if (c.image_height == '0) begin
      e.h = RA_W'(1);
    end else if (32'(c.image_height) > 32'(MAX_HEIGHT)) begin
      e.h = RA_W'(MAX_HEIGHT);
    end else begin
      e.h = RA_W'(c.image_height);
    end
    if (c.win_rows == '0) begin
      e.wr = WN_W'(1);
    end else if (32'(c.win_rows) > 32'(MAX_WIN)) begin
      e.wr = WN_W'(MAX_WIN);
    end else begin
      e.wr = WN_W'(c.win_rows);
    end
    if (c.win_cols == '0) begin
      e.wc = WN_W'(1);
    end else if (32'(c.win_cols) > 32'(MAX_WIN)) begin
      e.wc = WN_W'(MAX_WIN);
    end else begin
      e.wc = WN_W'(c.win_cols);
    end
    e.s = (c.step_size == '0) ? STEP_BITS'(1) : c.step_size;
    return e;
  endfunction

endpackage

[hdl/max_pool_2d_window.sv]
// Streaming 2D max pooling. Samples (signed Q8.8) arrive in raster order and
// are stored in a ring of the last four rows; first_of_frame in tuser restarts
// at row 0, column 0. When a sample is the bottom-right corner of a window on
// the stride grid, the window maximum leaves on the master stream, with tlast
// on the final window of the image. The block works on one sample at a time
// and takes no new sample until it is through with the last. The grid test
// finds the row and column remainders four bits per cycle; a sample that
// completes a window then has the compare unit read the window from the
// single-port ring, one entry per cycle, before the result is delivered.
// A finished result waits in the output register while the next sample is
// taken. Registers (APB, byte address 4*i): image_width, image_height,
// win_rows, win_cols, step_size; change them only while the block is idle.
module max_pool_2d_window import mp2d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Sample stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // [15:0] sample
  input  logic               s_axis_tuser,  // [0] first_of_frame
  // Result stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // [15:0] pooled
  output logic               m_axis_tlast,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg_q;
  eff_t  eff;
  cmd_t  cmd;
  stat_t stat;
  logic  reg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  sample_t pooled;

  assign pready  = 1'b1;
  assign reg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= RST_IMAGE_WIDTH;
      cfg_q.image_height <= RST_IMAGE_HEIGHT;
      cfg_q.win_rows     <= RST_WIN_ROWS;
      cfg_q.win_cols     <= RST_WIN_COLS;
      cfg_q.step_size    <= RST_STEP_SIZE;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[IW_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[IH_BITS-1:0];
        REG_WIN_ROWS:     cfg_q.win_rows     <= pwdata[WIN_BITS-1:0];
        REG_WIN_COLS:     cfg_q.win_cols     <= pwdata[WIN_BITS-1:0];
        REG_STEP_SIZE:    cfg_q.step_size    <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(cfg_q.image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.image_height);
      REG_WIN_ROWS:     prdata = 32'(cfg_q.win_rows);
      REG_WIN_COLS:     prdata = 32'(cfg_q.win_cols);
      REG_STEP_SIZE:    prdata = 32'(cfg_q.step_size);
      default:          prdata = '0;
    endcase
  end

  assign eff = make_eff(cfg_q);

  mp2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  mp2d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_i       (eff),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .sample_i    (sample_t'(s_axis_tdata[SAMPLE_BITS-1:0])),
    .first_i     (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .pooled_o    (pooled),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'($unsigned(pooled));

endmodule

[hdl/mp2d_rem.sv]
module mp2d_rem import mp2d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_W-1:0]     dividend_i,
  input  logic [STEP_BITS-1:0] divisor_i,
  output logic [STEP_BITS-1:0] rem_o,
  output logic                 done_o
);

  logic [DIV_W-1:0]     shift_q, shift_d;
  logic [STEP_BITS-1:0] rem_q, rem_d;
  logic [DSC_W-1:0]     cnt_q, cnt_d;

  // Restoring remainder, one digit of the dividend per cycle, MSB first.
  always_comb begin
    logic [STEP_BITS:0] part;
    part    = '0;
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      cnt_d   = DSC_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      for (int k = 0; k < DIG_BITS; k++) begin
        part = {rem_d, shift_q[DIV_W-1-k]};
        if (part >= {1'b0, divisor_i}) begin
          part = part - {1'b0, divisor_i};
        end
        rem_d = part[STEP_BITS-1:0];
      end
      shift_d = shift_q << DIG_BITS;
      cnt_d   = cnt_q - 1'b1;
    end
  end

  // Digit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

endmodule

[hdl/mp2d_ctrl.sv]
module mp2d_ctrl import mp2d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_ready_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_POS   = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_q, state_d;

  // Sequence one sample: place it, test the grid and, on a hit, walk the window and deliver.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_POS;
        end
      end
      ST_POS: begin
        cmd_o.pos_calc = 1'b1;
        state_d        = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = stat_i.hit ? ST_WALK : ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/mp2d_dp.sv]
module mp2d_dp import mp2d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  eff_t    eff_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  input  sample_t sample_i,
  input  logic    first_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output sample_t pooled_o,
  output logic    last_o
);

  // Ring of the most recent rows, one row per line.
  sample_t ring_mem [MAX_WIN][MAX_WIDTH];

  sample_t sample_q;
  logic    first_q;

  logic [ROW_W-1:0] pos_row_q;
  logic [COL_W-1:0] pos_col_q;
  logic [RR_W-1:0]  pos_rr_q;

  logic [ROW_W-1:0] cur_row_q;
  logic [COL_W-1:0] cur_col_q;
  logic [RR_W-1:0]  cur_rr_q;

  logic [ROW_W-1:0] dr_q;
  logic [COL_W-1:0] dc_q;
  logic             ok_r_q, ok_c_q;
  logic [RR_W-1:0]  rr_top_q;

  logic [RR_W-1:0]  wi_q, wj_q;
  logic             rd_valid_q;
  sample_t          rd_data_q;
  sample_t          best_q;
  logic             best_first_q;

  logic             out_valid_q;
  sample_t          pooled_q;
  logic             last_q;

  function automatic logic [RR_W-1:0] rr_inc(logic [RR_W-1:0] v);
    logic [RR_W:0] t;
    t = {1'b0, v} + 1'b1;
    if (t >= (RR_W + 1)'(MAX_WIN)) begin
      t = '0;
    end
    return t[RR_W-1:0];
  endfunction

  // Position of the incoming sample, after frame restart and wraps.
  logic [ROW_W-1:0] row_a, row_c;
  logic [COL_W-1:0] col_a, col_b;
  logic [RR_W-1:0]  rr_a, rr_b, rr_c;
  logic [RA_W-1:0]  row_b;
  logic             col_wrap, row_wrap;

  always_comb begin
    row_a    = first_q ? '0 : pos_row_q;
    col_a    = first_q ? '0 : pos_col_q;
    rr_a     = first_q ? '0 : pos_rr_q;
    col_wrap = (CA_W'(col_a) >= eff_i.w);
    row_b    = col_wrap ? RA_W'(row_a) + 1'b1 : RA_W'(row_a);
    rr_b     = col_wrap ? rr_inc(rr_a) : rr_a;
    col_b    = col_wrap ? '0 : col_a;
    row_wrap = (row_b >= eff_i.h);
    row_c    = row_wrap ? '0 : row_b[ROW_W-1:0];
    rr_c     = row_wrap ? '0 : rr_b;
  end

  // Window origin offsets, next position and top ring line of the window.
  logic [RA_W-1:0]  r1, dr_full;
  logic [CA_W-1:0]  c1, dc_full;
  logic [RR_W+1:0]  top_sum;
  logic [RR_W-1:0]  rr_top;
  logic [RR_W-1:0]  rr_next;

  always_comb begin
    r1      = RA_W'(cur_row_q) + 1'b1;
    c1      = CA_W'(cur_col_q) + 1'b1;
    dr_full = r1 - RA_W'(eff_i.wr);
    dc_full = c1 - CA_W'(eff_i.wc);
    top_sum = (RR_W + 2)'(cur_rr_q) + (RR_W + 2)'(MAX_WIN)
            - ((RR_W + 2)'(eff_i.wr) - 1'b1);
    if (top_sum >= (RR_W + 2)'(MAX_WIN)) begin
      top_sum = top_sum - (RR_W + 2)'(MAX_WIN);
    end
    rr_top  = top_sum[RR_W-1:0];
    rr_next = rr_inc(cur_rr_q);
  end

  // Grid test on both axes.
  logic [STEP_BITS-1:0] rem_r, rem_c;
  logic                 done_r, done_c;

  mp2d_rem u_rem_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.prep),
    .dividend_i (DIV_W'(dr_full[ROW_W-1:0])),
    .divisor_i  (eff_i.s),
    .rem_o      (rem_r),
    .done_o     (done_r)
  );

  mp2d_rem u_rem_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.prep),
    .dividend_i (DIV_W'(dc_full[COL_W-1:0])),
    .divisor_i  (eff_i.s),
    .rem_o      (rem_c),
    .done_o     (done_c)
  );

  // Ring read address during the window walk.
  logic [RR_W:0]    rd_row_sum;
  logic [RR_W-1:0]  rd_row;
  logic [COL_W-1:0] rd_col;
  logic             col_end, row_end;

  always_comb begin
    rd_row_sum = {1'b0, rr_top_q} + {1'b0, wi_q};
    if (rd_row_sum >= (RR_W + 1)'(MAX_WIN)) begin
      rd_row_sum = rd_row_sum - (RR_W + 1)'(MAX_WIN);
    end
    rd_row  = rd_row_sum[RR_W-1:0];
    rd_col  = dc_q + COL_W'(wj_q);
    col_end = (WN_W'(wj_q) == eff_i.wc - 1'b1);
    row_end = (WN_W'(wi_q) == eff_i.wr - 1'b1);
  end

  // The result is the last one of the image when no further origin fits.
  logic last_c;
  assign last_c = (RA_W'(dr_q) + RA_W'(eff_i.s) + RA_W'(eff_i.wr) > eff_i.h) &&
                  (CA_W'(dc_q) + CA_W'(eff_i.s) + CA_W'(eff_i.wc) > eff_i.w);

  // Ring memory: written when a sample is placed, read during the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_calc) begin
      ring_mem[rr_c][col_b] <= sample_q;
    end
    if (cmd_i.walk) begin
      rd_data_q <= ring_mem[rd_row][rd_col];
    end
  end

  // Stored position of the next sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q <= '0;
      pos_col_q <= '0;
      pos_rr_q  <= '0;
    end else if (cmd_i.prep) begin
      if (c1 >= eff_i.w) begin
        pos_col_q <= '0;
        if (r1 >= eff_i.h) begin
          pos_row_q <= '0;
          pos_rr_q  <= '0;
        end else begin
          pos_row_q <= r1[ROW_W-1:0];
          pos_rr_q  <= rr_next;
        end
      end else begin
        pos_col_q <= c1[COL_W-1:0];
        pos_row_q <= cur_row_q;
        pos_rr_q  <= cur_rr_q;
      end
    end
  end

  // Sample registers, current position and window geometry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      sample_q <= sample_i;
      first_q  <= first_i;
    end
    if (cmd_i.pos_calc) begin
      cur_row_q <= row_c;
      cur_col_q <= col_b;
      cur_rr_q  <= rr_c;
    end
    if (cmd_i.prep) begin
      dr_q     <= dr_full[ROW_W-1:0];
      dc_q     <= dc_full[COL_W-1:0];
      ok_r_q   <= (r1 >= RA_W'(eff_i.wr));
      ok_c_q   <= (c1 >= CA_W'(eff_i.wc));
      rr_top_q <= rr_top;
    end
  end

  // Window walk counters, column first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      wi_q <= '0;
      wj_q <= '0;
    end else if (cmd_i.walk) begin
      if (col_end) begin
        wj_q <= '0;
        wi_q <= wi_q + 1'b1;
      end else begin
        wj_q <= wj_q + 1'b1;
      end
    end
  end

  // Running maximum over the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.walk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      best_first_q <= 1'b1;
    end else if (rd_valid_q) begin
      best_first_q <= 1'b0;
      if (best_first_q || (rd_data_q > best_q)) begin
        best_q <= rd_data_q;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pooled_q <= best_q;
      last_q   <= last_c;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pooled_o         = pooled_q;
  assign last_o           = last_q;
  assign stat_o.div_done  = done_r & done_c;
  assign stat_o.hit       = ok_r_q & ok_c_q & (rem_r == '0) & (rem_c == '0);
  assign stat_o.walk_done = col_end & row_end;
  assign stat_o.out_busy  = out_valid_q & ~out_ready_i;

endmodule

[hdl/mp2d_checker.sv]
module mp2d_checker import mp2d_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // One sample at a time: an input transaction closes the input side.
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on two consecutive cycles");

  // A new result is loaded only at the end of a sample's work.
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the block was idle");

  // No result is offered during reset.
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind max_pool_2d_window mp2d_checker u_mp2d_checker (.*);

[sim/max_pool_2d_window_test.sv]
module max_pool_2d_window_test;
  import mp2d_pkg::*;

  // Cycles with no transaction on any port before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time after the last result, long enough for one sample's grid
  // test, window walk and delivery.
  localparam int DRAIN_CYCLES   = 40;
  localparam int TOTAL_SAMPLES  = 1600;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    sample_t value;
    logic    frame_start;
  } pixel_t;

  typedef struct packed {
    sample_t pooled;
    logic    last;
  } pool_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;  // [15:0] sample
  logic               s_axis_tuser  = 1'b0;  // [0] first_of_frame
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;  // [15:0] pooled
  logic               m_axis_tlast;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [ADDR_W-1:0]  paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Samples waiting to be sent and window maxima waiting to arrive.
  pixel_t       pixel_queue[$];
  pool_result_t pooled_expected[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int error_count   = 0;
  int idle_cycles   = 0;
  int fed_items     = 0;
  int phase_count   = 0;

  // Shadow of the registers and of the row store, kept in step with the block.
  logic [IW_BITS-1:0]   width_reg    = RST_IMAGE_WIDTH;
  logic [IH_BITS-1:0]   height_reg   = RST_IMAGE_HEIGHT;
  logic [WIN_BITS-1:0]  win_rows_reg = RST_WIN_ROWS;
  logic [WIN_BITS-1:0]  win_cols_reg = RST_WIN_COLS;
  logic [STEP_BITS-1:0] step_reg     = RST_STEP_SIZE;
  sample_t              row_store [MAX_WIN*MAX_WIDTH];
  int                   cur_row = 0;
  int                   cur_col = 0;

  max_pool_2d_window DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Zero acts as one and anything above the maximum acts as the maximum.
  function automatic int clamp_reg(int value, int hi);
    if (value == 0) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  // Stores one sample and queues the window maximum if it closes a window.
  function automatic void pool_pixel(sample_t value, logic frame_start);
    int w, h, wr, wc, s, r, c, r0, c0, i, j;
    sample_t best;
    pool_result_t res;
    w  = clamp_reg(int'(width_reg), MAX_WIDTH);
    h  = clamp_reg(int'(height_reg), MAX_HEIGHT);
    wr = clamp_reg(int'(win_rows_reg), MAX_WIN);
    wc = clamp_reg(int'(win_cols_reg), MAX_WIN);
    s  = (step_reg == '0) ? 1 : int'(step_reg);
    if (frame_start) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    r = cur_row;
    c = cur_col;
    row_store[(r % MAX_WIN) * MAX_WIDTH + c] = value;

    if (r + 1 >= wr && c + 1 >= wc && (r + 1 - wr) % s == 0 && (c + 1 - wc) % s == 0) begin
      r0 = r + 1 - wr;
      c0 = c + 1 - wc;
      best = row_store[(r0 % MAX_WIN) * MAX_WIDTH + c0];
      for (i = r0; i <= r; i++) begin
        for (j = c0; j <= c; j++) begin
          if (row_store[(i % MAX_WIN) * MAX_WIDTH + j] > best) begin
            best = row_store[(i % MAX_WIN) * MAX_WIDTH + j];
          end
        end
      end
      res.pooled = best;
      res.last   = (r0 == ((h - wr) / s) * s) && (c0 == ((w - wc) / s) * s);
      pooled_expected.push_back(res);
    end

    // Advance in raster order, wrapping at the end of the image.
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endfunction

  // Mostly random samples, with the extremes of the range mixed in.
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'shFFFF;
      3: return 16'sh0000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void add_pixel(sample_t value, logic frame_start);
    pixel_t px;
    px.value       = value;
    px.frame_start = frame_start;
    pixel_queue.push_back(px);
    fed_items++;
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 79;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 79;
      end
      default: begin
        send_idle_pct = 6;
        stall_pct     = 6;
      end
    endcase
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  width_reg    = IW_BITS'(value);
      REG_IMAGE_HEIGHT: height_reg   = IH_BITS'(value);
      REG_WIN_ROWS:     win_rows_reg = WIN_BITS'(value);
      REG_WIN_COLS:     win_cols_reg = WIN_BITS'(value);
      REG_STEP_SIZE:    step_reg     = STEP_BITS'(value);
      default: ;
    endcase
  endtask

  // New phase: rotate the idling pattern and load a full set of registers.
  task automatic start_phase(int w, int h, int wr, int wc, int s);
    set_idling(idle_mode_e'(phase_count % 4));
    phase_count++;
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WIN_ROWS, wr);
    write_reg(REG_WIN_COLS, wc);
    write_reg(REG_STEP_SIZE, s);
  endtask

  // Waits until every sample is taken and every result has come back, then
  // gives the block time to finish a sample that closes no window.
  task automatic drain();
    while (pixel_queue.size() != 0 || s_axis_tvalid || pooled_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sample driver: predicts on each accepted transaction, then offers the
  // next sample unless the sender is idling.
  always @(posedge clk_i) begin : drive_samples
    pixel_t next_px;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pool_pixel(sample_t'(s_axis_tdata[SAMPLE_BITS-1:0]), s_axis_tuser);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_px = pixel_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TDATA_W'(next_px.value);
          s_axis_tuser  <= next_px.frame_start;
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= TDATA_W'($urandom);
          s_axis_tuser  <= 1'(($urandom));
        end
      end
    end
  end

  // Result monitor: compares each result transaction with the oldest
  // expected window maximum.
  always @(posedge clk_i) begin : check_results
    pool_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pooled_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual pooled %h last %b",
                   $time, m_axis_tdata[SAMPLE_BITS-1:0], m_axis_tlast);
          error_count++;
        end else begin
          want = pooled_expected.pop_front();
          if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.pooled) begin
            $display("%0t: pooled mismatch, expected %h, actual %h",
                     $time, want.pooled, m_axis_tdata[SAMPLE_BITS-1:0]);
            error_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, want.last, m_axis_tlast);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("max_pool_2d_window verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int w, h, wr, wc, s, w_eff, h_eff, n, f, k;
    sample_t frame_a [20] = '{
      16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh8000,
      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001,
      16'sh1234, 16'shEDCB,
      16'sh7FFF, 16'sh7FFE, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh5555
    };

    // Assert reset before the first clock edge.
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values: two full 256-wide rows and six more.
    set_idling(IDLE_BOTH);
    for (k = 0; k < 2 * MAX_WIDTH + 6; k++) add_pixel(pick_sample(), k == 0);
    drain();

    // 3x2 image, 2x2 window: one frame, a wrap into the next image, a partial
    // row, and a restart in the middle of the image.
    start_phase(3, 2, 2, 2, 1);
    foreach (frame_a[k]) add_pixel(frame_a[k], k == 0 || k == 14);
    drain();

    // Window taller than the image: nothing comes out.
    start_phase(2, 2, 3, 1, 1);
    for (k = 0; k < 4; k++) add_pixel(pick_sample(), k == 0);
    drain();

    // All registers zero act as a 1x1 image with a 1x1 window.
    start_phase(0, 0, 0, 0, 0);
    for (k = 0; k < 3; k++) add_pixel(pick_sample(), k == 0);
    drain();

    // Oversized windows clamp to 4x4; a stride of 5 leaves one window.
    start_phase(6, 4, 7, 6, 5);
    for (k = 0; k < 24; k++) add_pixel(pick_sample(), k == 0);
    drain();

    // Width and height above their maxima clamp.
    start_phase(300, 8191, 1, 2, 1);
    for (k = 0; k < MAX_WIDTH + 4; k++) add_pixel(pick_sample(), k == 0);
    drain();

    // Random settings with mostly well-formed frames and some restarts.
    while (fed_items < TOTAL_SAMPLES) begin
      case ($urandom_range(39))
        0: w = $urandom_range(511, MAX_WIDTH + 1);
        1: w = MAX_WIDTH;
        2: w = 0;
        default: w = $urandom_range(12, 1);
      endcase
      case ($urandom_range(19))
        0: h = $urandom_range(8191, MAX_HEIGHT + 1);
        1: h = 0;
        2: h = MAX_HEIGHT;
        default: h = $urandom_range(8, 1);
      endcase
      wr = ($urandom_range(9) < 7) ? $urandom_range(3, 1) : $urandom_range(7, 0);
      wc = ($urandom_range(9) < 7) ? $urandom_range(3, 1) : $urandom_range(7, 0);
      s  = ($urandom_range(9) < 7) ? $urandom_range(2, 1) : $urandom_range(7, 0);
      w_eff = clamp_reg(w, MAX_WIDTH);
      h_eff = clamp_reg(h, MAX_HEIGHT);
      start_phase(w, h, wr, wc, s);

      if (w_eff * h_eff <= 120) begin
        // Whole frames; later frames may rely on the wrap at image end.
        n = $urandom_range(4, 1);
        for (f = 0; f < n; f++) begin
          for (k = 0; k < w_eff * h_eff; k++) begin
            add_pixel(pick_sample(),
                      (k == 0 && (f == 0 || $urandom_range(4) != 0)) ||
                      $urandom_range(99) < 3);
          end
        end
      end else begin
        // Large image: a few rows only.
        if (w_eff > 64) begin
          n = 2 * w_eff + $urandom_range(w_eff);
        end else begin
          n = w_eff * $urandom_range(8, 2) + $urandom_range(w_eff);
        end
        for (k = 0; k < n; k++) add_pixel(pick_sample(), k == 0 || $urandom_range(99) < 3);
      end
      drain();
    end

    if (error_count == 0 && pooled_expected.size() == 0) begin
      $display("max_pool_2d_window verification clean");
    end else begin
      $display("max_pool_2d_window verification failed");
    end
    $finish;
  end

endmodule
